FILE: hdl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// Shared widths, codes and record types of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int CONNS     = 1024;
  localparam int CONN_W    = 10;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int HDR_BYTES = 4;
  localparam int HDR_W     = 24;
  localparam int ADDR_W    = (CONNS > 1) ? $clog2(CONNS) : 1;
  localparam int ENTRY_W   = HDR_W + 2 * LEN_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  // action codes
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // per-connection table entry
  typedef struct packed {
    logic [HDR_W-1:0] hdr;
    logic [LEN_W-1:0] seen;
    logic [LEN_W-1:0] len;
  } entry_t;

  // one queued record: a released header (four beats) or one body byte
  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic [BYTE_W-1:0] data;
    logic [HDR_W-1:0]  hdr;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
    logic              is_hdr;
    logic              last;
    logic              bad;
  } rec_t;

endpackage

FILE: hdl/pld_if.sv
// ----------------------------------------------------------------------------
// pld_if
// Valid/ready channels of the deframer: input beats and message-byte beats.
// ----------------------------------------------------------------------------
interface pld_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [pld_pkg::CONN_W-1:0] conn;
  logic [pld_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output conn, output data_byte, input ready);
  modport sink   (input valid, input action, input conn, input data_byte, output ready);
endinterface

interface pld_out_if;
  logic                       valid;
  logic                       ready;
  logic [pld_pkg::CONN_W-1:0] out_conn;
  logic [pld_pkg::BYTE_W-1:0] out_byte;
  logic [pld_pkg::LEN_W-1:0]  msg_length;
  logic [pld_pkg::LEN_W-1:0]  byte_position;
  logic                       first_byte;
  logic                       last_byte;
  logic                       bad_length;

  modport source (output valid, output out_conn, output out_byte, output msg_length,
                  output byte_position, output first_byte, output last_byte,
                  output bad_length, input ready);
  modport sink   (input valid, input out_conn, input out_byte, input msg_length,
                  input byte_position, input first_byte, input last_byte,
                  input bad_length, output ready);
endinterface

FILE: hdl/pld_ram.sv
// ----------------------------------------------------------------------------
// pld_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pld_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pld_emit.sv
// ----------------------------------------------------------------------------
// pld_emit
// Record queue and beat serializer: a header record leaves as four beats,
// a body record as one.
// ----------------------------------------------------------------------------
module pld_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  pld_pkg::rec_t                 rec_i,
  output logic [pld_pkg::FIFO_CW-1:0]   cnt_o,
  pld_out_if.source                     out_o
);
  import pld_pkg::*;

  localparam logic [1:0] SubLast = 2'd3;

  rec_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic [1:0]         sub_q;
  rec_t               head;
  logic               beat;
  logic               pop;
  logic [BYTE_W-1:0]  hdr_byte;

  assign head = fifo_q[rd_ptr_q];
  assign beat = out_o.valid && out_o.ready;
  assign pop  = beat && (!head.is_hdr || (sub_q == SubLast));

  always_comb begin
    case (sub_q)
      2'd0:    hdr_byte = head.hdr[7:0];
      2'd1:    hdr_byte = head.hdr[15:8];
      2'd2:    hdr_byte = head.hdr[23:16];
      default: hdr_byte = head.data;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + FIFO_CW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      sub_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
        sub_q    <= '0;
      end else if (beat) begin
        sub_q <= sub_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= rec_i;
    end
  end

  assign cnt_o               = cnt_q;
  assign out_o.valid         = (cnt_q != '0);
  assign out_o.out_conn      = head.conn;
  assign out_o.out_byte      = head.is_hdr ? hdr_byte : head.data;
  assign out_o.msg_length    = head.len;
  assign out_o.byte_position = head.is_hdr ? LEN_W'(sub_q) : head.pos;
  assign out_o.first_byte    = head.is_hdr && (sub_q == 2'd0);
  assign out_o.last_byte     = head.last && (!head.is_hdr || (sub_q == SubLast));
  assign out_o.bad_length    = head.is_hdr && head.bad;

endmodule

FILE: hdl/per_connection_length_deframer.sv
// ----------------------------------------------------------------------------
// per_connection_length_deframer
// Reassembles length-prefixed messages from byte streams interleaved over
// many connections, with per-connection state kept in one table RAM.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    action, conn, data_byte
//   out_o    out  valid/ready    out_conn, out_byte, msg_length,
//                                byte_position, first_byte, last_byte,
//                                bad_length
//
// One input beat per cycle unless stalled; the table read-modify-write (RAM
// read, then update and write in the next cycle, forwarding the last write)
// sets that. A header byte 3 yields four output beats, a body byte one, other
// beats none. After reset a clearing pass writes all CONNS entries, one per
// cycle, with in_i.ready low. Otherwise input stalls only when the four-deep
// record queue may fill up, behind a stalled output or a header burst.
// ----------------------------------------------------------------------------
module per_connection_length_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  pld_in_if.sink    in_i,
  pld_out_if.source out_o
);
  import pld_pkg::*;

  localparam logic [LEN_W-1:0] HdrLen  = LEN_W'(HDR_BYTES);
  localparam logic [LEN_W-1:0] HdrLast = LEN_W'(HDR_BYTES - 1);

  // clearing pass
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // stage 1: table entry arrives from RAM
  logic              s1_valid_q;
  logic              s1_action_q;
  logic [CONN_W-1:0] s1_conn_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic [ADDR_W-1:0] s1_addr_q;

  // last write, forwarded to a read issued on the same edge
  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  entry_t            fwd_data_q;

  logic               in_beat;
  logic               conn_ok;
  logic [ADDR_W-1:0]  in_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ent;
  entry_t             upd;
  logic               push;
  rec_t               rec;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [LEN_W-1:0]   hdr_len;
  logic               body_end;

  assign in_addr = ADDR_W'(in_i.conn);
  assign conn_ok = (int'(in_i.conn) < CONNS);
  assign in_i.ready = !clr_busy_q
                    && ((FIFO_CW + 1)'(fifo_cnt) + (FIFO_CW + 1)'(s1_valid_q)
                        < (FIFO_CW + 1)'(FIFO_DEPTH));
  assign in_beat = in_i.valid && in_i.ready;

  always_comb begin
    ent = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : entry_t'(ram_rdata);
    upd      = ent;
    push     = 1'b0;
    hdr_len  = {ent.hdr[23:16], s1_byte_q};
    body_end = ({1'b0, ent.seen} + (LEN_W + 1)'(1)) >= {1'b0, ent.len};
    rec.conn   = s1_conn_q;
    rec.data   = s1_byte_q;
    rec.hdr    = ent.hdr;
    rec.len    = ent.len;
    rec.pos    = ent.seen;
    rec.is_hdr = 1'b0;
    rec.last   = 1'b0;
    rec.bad    = 1'b0;

    if (s1_action_q == ACT_CLEAR) begin
      upd = '0;
    end else if (ent.seen < HdrLast) begin
      // hold header bytes 0..2
      case (ent.seen[1:0])
        2'd0:    upd.hdr[7:0]   = s1_byte_q;
        2'd1:    upd.hdr[15:8]  = s1_byte_q;
        default: upd.hdr[23:16] = s1_byte_q;
      endcase
      upd.seen = ent.seen + LEN_W'(1);
    end else if (ent.seen == HdrLast) begin
      // release the whole header
      push       = s1_valid_q;
      rec.len    = hdr_len;
      rec.pos    = HdrLast;
      rec.is_hdr = 1'b1;
      rec.bad    = hdr_len < HdrLen;
      rec.last   = hdr_len <= HdrLen;
      if (hdr_len <= HdrLen) begin
        upd = '0;
      end else begin
        upd.seen = HdrLen;
        upd.len  = hdr_len;
      end
    end else begin
      push     = s1_valid_q;
      rec.last = body_end;
      if (body_end) begin
        upd = '0;
      end else begin
        upd.seen = ent.seen + LEN_W'(1);
      end
    end
  end

  assign ram_we    = clr_busy_q || s1_valid_q;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : ENTRY_W'(upd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(CONNS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      // drop beats for connections outside the table
      s1_valid_q  <= in_beat && conn_ok;
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_action_q <= in_i.action;
      s1_conn_q   <= in_i.conn;
      s1_byte_q   <= in_i.data_byte;
      s1_addr_q   <= in_addr;
    end
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= upd;
  end

  pld_ram #(
    .Width (ENTRY_W),
    .Depth (CONNS),
    .AddrW (ADDR_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  pld_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .cnt_o  (fifo_cnt),
    .out_o  (out_o)
  );

  // the record queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || (out_o.valid && out_o.ready))
    else $error("record queue overflow");

  // no table update from an item competes with the clearing pass
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |=> !s1_valid_q)
    else $error("item entered during clearing pass");

  // a header that ends the message has a length of at most four
  a_short_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && rec.is_hdr && rec.last) |-> (rec.len <= HdrLen))
    else $error("header ended a long message");

  // a first beat always sits at offset zero and is never last
  a_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.first_byte) |-> (out_o.byte_position == '0) && !out_o.last_byte)
    else $error("malformed first beat");

endmodule

FILE: tb/tb_per_connection_length_deframer.sv
// ----------------------------------------------------------------------------
// tb_per_connection_length_deframer
// Drives interleaved byte streams and clears into the deframer and checks
// every message-byte beat, in order, against a per-connection model of
// header holding, header release, body pass-through and message end.
// Both channels stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_per_connection_length_deframer;
  import pld_pkg::*;

  localparam int RANDOM_BEATS   = 250;
  localparam int STALL_PCT      = 35;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  // one message byte as it leaves the block
  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
    logic              first;
    logic              last;
    logic              bad;
  } msg_beat_t;

  // one input beat; typed rows also carry the count and the final beat expected
  typedef struct packed {
    logic              act;
    logic [CONN_W-1:0] conn;
    logic [BYTE_W-1:0] data;
    logic              typed;
    logic [2:0]        n_beats;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
    logic              last;
    logic              bad;
  } feed_row_t;

  //  act        conn      data   typed n     len        pos     last  bad
  localparam feed_row_t DIRECTED_ROWS [0:24] = '{
    // length 4: message ends on header byte 3
    '{ACT_DATA,  10'd0,    8'h00, 1'b1, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd0,    8'hFF, 1'b1, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd0,    8'h00, 1'b1, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd0,    8'h04, 1'b1, 3'd4, 16'd4,     16'd3, 1'b1, 1'b0},
    // length 0 on the top connection: flagged, cut at the header
    '{ACT_DATA,  10'd1023, 8'hFF, 1'b1, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd1023, 8'h00, 1'b1, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd1023, 8'h00, 1'b1, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd1023, 8'h00, 1'b1, 3'd4, 16'd0,     16'd3, 1'b1, 1'b1},
    // length 6: two body bytes
    '{ACT_DATA,  10'd5,    8'hA5, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd5,    8'h5A, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd5,    8'h00, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd5,    8'h06, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd5,    8'h11, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd5,    8'hEE, 1'b1, 3'd1, 16'd6,     16'd5, 1'b1, 1'b0},
    // maximum length, cut short by a clear, then a fresh message
    '{ACT_DATA,  10'd9,    8'h00, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'h00, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'hFF, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'hFF, 1'b1, 3'd4, 16'hFFFF,  16'd3, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'h7F, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_CLEAR, 10'd9,    8'h00, 1'b1, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'h12, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'h34, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'h00, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'h05, 1'b0, 3'd0, 16'd0,     16'd0, 1'b0, 1'b0},
    '{ACT_DATA,  10'd9,    8'h56, 1'b1, 3'd1, 16'd5,     16'd4, 1'b1, 1'b0}
  };

  logic clk;
  logic rst_n;

  pld_in_if  in_ch ();
  pld_out_if out_ch ();

  per_connection_length_deframer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // per-connection deframing state
  logic [HDR_W-1:0] hdr_held [CONNS];
  logic [LEN_W-1:0] seen_cnt [CONNS];
  logic [LEN_W-1:0] msg_len  [CONNS];

  msg_beat_t step_beats [4];
  msg_beat_t expected_bytes [$];
  feed_row_t feed_rows [$];
  feed_row_t msg_plan [4][$];

  feed_row_t cur_row;
  msg_beat_t got_beat;
  msg_beat_t want_beat;
  int        n_new;
  int        mismatches;
  int        idle_cycles;
  int        beats_in;
  int        clears_in;
  int        headers_done;
  int        bad_headers;
  int        bytes_out;
  bit        steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (hdr_held[i]) begin
      hdr_held[i] = '0;
      seen_cnt[i] = '0;
      msg_len[i]  = '0;
    end
  end

  function automatic void forget_conn(input logic [CONN_W-1:0] c);
    hdr_held[c] = '0;
    seen_cnt[c] = '0;
    msg_len[c]  = '0;
  endfunction

  // Advance one connection by one input beat; fill step_beats, return their count.
  function automatic int deframe(input feed_row_t r);
    logic [LEN_W-1:0] seen;
    logic [LEN_W-1:0] len;
    logic             bad;
    logic             done;
    int               idx;
    if (r.act == ACT_CLEAR) begin
      forget_conn(r.conn);
      return 0;
    end
    seen = seen_cnt[r.conn];
    idx  = int'(seen);
    if (idx < HDR_BYTES - 1) begin
      hdr_held[r.conn][8*idx +: 8] = r.data;
      seen_cnt[r.conn] = seen + 1'b1;
      return 0;
    end
    if (idx == HDR_BYTES - 1) begin
      len  = {hdr_held[r.conn][23:16], r.data};
      bad  = (len < HDR_BYTES);
      done = (len <= HDR_BYTES);
      for (int k = 0; k < HDR_BYTES - 1; k++) begin
        step_beats[k] = '{conn: r.conn, data: hdr_held[r.conn][8*k +: 8], len: len,
                          pos: LEN_W'(k), first: (k == 0), last: 1'b0, bad: bad};
      end
      step_beats[3] = '{conn: r.conn, data: r.data, len: len, pos: LEN_W'(3),
                        first: 1'b0, last: done, bad: bad};
      if (done) begin
        forget_conn(r.conn);
      end else begin
        seen_cnt[r.conn] = LEN_W'(HDR_BYTES);
        msg_len[r.conn]  = len;
      end
      return 4;
    end
    len  = msg_len[r.conn];
    done = (idx + 1 >= int'(len));
    step_beats[0] = '{conn: r.conn, data: r.data, len: len, pos: seen,
                      first: 1'b0, last: done, bad: 1'b0};
    if (done) begin
      forget_conn(r.conn);
    end else begin
      seen_cnt[r.conn] = seen + 1'b1;
    end
    return 1;
  endfunction

  task automatic note_mismatch(input string what, input msg_beat_t want, input msg_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch %0d, %s: expected conn=%0d byte=%02h len=%0d pos=%0d f=%0b l=%0b bad=%0b",
               mismatches, what, want.conn, want.data, want.len, want.pos, want.first,
               want.last, want.bad);
      $display("    got conn=%0d byte=%02h len=%0d pos=%0d f=%0b l=%0b bad=%0b",
               got.conn, got.data, got.len, got.pos, got.first, got.last, got.bad);
    end
  endtask

  // Predict on accepted input beats, then check accepted output beats.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cur_row = feed_rows.pop_front();
      n_new   = deframe(cur_row);
      if (cur_row.typed) begin
        n_new = int'(cur_row.n_beats);
        if (n_new > 0) begin
          step_beats[n_new-1] = '{conn: cur_row.conn, data: cur_row.data, len: cur_row.len,
                                  pos: cur_row.pos, first: 1'b0, last: cur_row.last,
                                  bad: cur_row.bad};
        end
      end
      for (int k = 0; k < n_new; k++) expected_bytes.push_back(step_beats[k]);
      beats_in++;
      if (cur_row.act == ACT_CLEAR) clears_in++;
      if (n_new == 4) begin
        headers_done++;
        if (step_beats[3].bad) bad_headers++;
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_beat = '{conn: out_ch.out_conn, data: out_ch.out_byte, len: out_ch.msg_length,
                   pos: out_ch.byte_position, first: out_ch.first_byte,
                   last: out_ch.last_byte, bad: out_ch.bad_length};
      bytes_out++;
      if (expected_bytes.size() == 0) begin
        note_mismatch("beat with nothing expected", '0, got_beat);
      end else begin
        want_beat = expected_bytes.pop_front();
        if (got_beat !== want_beat) note_mismatch("message byte", want_beat, got_beat);
      end
    end
  end

  // Count cycles with no beat on either side; the clearing pass fits well inside.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d bytes still expected",
                 idle_cycles, expected_bytes.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end
  end

  task automatic send_row(input feed_row_t r);
    if (!steady && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    feed_rows.push_back(r);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= r.act;
    in_ch.conn      <= r.conn;
    in_ch.data_byte <= r.data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Queue a message for slot s: sound, too short, or long and cut by a clear.
  task automatic plan_message(input int s);
    feed_row_t         r;
    logic [LEN_W-1:0]  len;
    logic [CONN_W-1:0] c;
    int                pick;
    int                body;
    pick = $urandom_range(99);
    c = (pick < 5) ? '0 : (pick < 10) ? '1 : CONN_W'($urandom_range(CONNS - 1));
    pick = $urandom_range(99);
    if (pick < 60) begin
      len  = LEN_W'($urandom_range(5, 12));
      body = int'(len) - HDR_BYTES;
    end else if (pick < 72) begin
      len  = LEN_W'(HDR_BYTES);
      body = 0;
    end else if (pick < 84) begin
      len  = LEN_W'($urandom_range(0, 3));
      body = 0;
    end else begin
      len  = LEN_W'($urandom_range(13, 65535));
      body = $urandom_range(0, 3);
    end
    r      = '0;
    r.act  = ACT_DATA;
    r.conn = c;
    for (int k = 0; k < HDR_BYTES + body; k++) begin
      if (k == 2)      r.data = len[15:8];
      else if (k == 3) r.data = len[7:0];
      else             r.data = BYTE_W'($urandom_range(255));
      msg_plan[s].push_back(r);
    end
    // drop the rest of a long message
    if (len > 12) begin
      r.act  = ACT_CLEAR;
      r.data = BYTE_W'($urandom_range(255));
      msg_plan[s].push_back(r);
    end
  endtask

  initial begin
    feed_row_t r;
    int        s;
    mismatches   = 0;
    beats_in     = 0;
    clears_in    = 0;
    headers_done = 0;
    bad_headers  = 0;
    bytes_out    = 0;
    idle_cycles  = 0;
    steady       = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_DATA;
    in_ch.conn      <= '0;
    in_ch.data_byte <= '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) send_row(DIRECTED_ROWS[i]);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      steady = (n >= 100 && n < 160);
      if ($urandom_range(99) < 10) begin
        r      = '0;
        r.act  = ($urandom_range(99) < 40) ? ACT_CLEAR : ACT_DATA;
        r.conn = CONN_W'($urandom_range(CONNS - 1));
        r.data = BYTE_W'($urandom_range(255));
      end else begin
        s = $urandom_range(3);
        if (msg_plan[s].size() == 0) plan_message(s);
        r = msg_plan[s].pop_front();
      end
      send_row(r);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats (%0d clears), %0d headers released (%0d bad length)",
             beats_in, clears_in, headers_done, bad_headers);
    $display("checked %0d message bytes, %0d mismatches", bytes_out, mismatches);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pld_pkg.sv
hdl/pld_if.sv
hdl/pld_ram.sv
hdl/pld_emit.sv
hdl/per_connection_length_deframer.sv
tb/tb_per_connection_length_deframer.sv
